[hw/rtl/kli_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kli_pkg
// Shared types and constants of the keyframe linear interpolator: transaction
// payloads, controller-to-datapath commands and datapath status.
// ----------------------------------------------------------------------------
package kli_pkg;

    localparam int KEY_IDX_W  = 6;
    localparam int KEY_CNT_W  = 7;
    localparam int DATA_W     = 32;
    localparam int FRAC_BITS  = 16;
    // one compare for the integer bit of the fraction, then FRAC_BITS more
    localparam int DIV_STEPS  = FRAC_BITS + 1;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_EVAL  = 1'b1;

    typedef struct packed {
        logic                 req_type;
        logic [KEY_IDX_W-1:0] key_index;
        logic [DATA_W-1:0]    key_time;
        logic [DATA_W-1:0]    key_value;
        logic [DATA_W-1:0]    position;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0]    value;
        logic [KEY_IDX_W-1:0] segment;
        logic                 no_segment;
    } t_out_item;

    typedef struct packed {
        logic mem_we;
        logic start;
        logic rd_en;
        logic adv;
        logic cap_seg;
        logic cap_last;
        logic div_step;
        logic div_first;
        logic mul;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic in_seg;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

[hw/rtl/kli_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kli_ctrl
// Controller: holds the key count register, sequences the segment scan, the
// fraction divide, the multiply and the result hand-off.
// ----------------------------------------------------------------------------
module kli_ctrl #(
    parameter int MAX_KEYS = 64,
    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [kli_pkg::KEY_CNT_W-1:0] i_cfg_data,
    input  wire logic                         i_in_valid,
    input  wire logic                         i_req_type,
    output logic                              o_in_ready,
    input  wire kli_pkg::t_status             i_status,
    output kli_pkg::t_cmd                     o_cmd,
    output logic [AW-1:0]                     o_rd_addr,
    output logic [AW-1:0]                     o_seg
);
    import kli_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_MUL,
        S_OUT
    } t_state;

    t_state               r_state;
    logic [KEY_CNT_W-1:0] r_key_count;
    logic [AW-1:0]        r_k;
    logic [AW-1:0]        r_last;
    logic [AW-1:0]        r_seg;
    logic [STEP_W-1:0]    r_step;

    logic [31:0]          kc32;
    logic [AW-1:0]        last_eff;
    logic                 acc;
    logic                 acc_eval;

    assign o_in_ready = (r_state == S_IDLE);
    assign acc        = i_in_valid && o_in_ready;
    assign acc_eval   = acc && (i_req_type == REQ_EVAL);
    assign o_seg      = r_seg;

    // clamp the key count to 1..MAX_KEYS and keep the last index
    assign kc32 = 32'(r_key_count);
    always_comb begin
        if (kc32 == 32'd0) begin
            last_eff = '0;
        end else if (kc32 > 32'(MAX_KEYS)) begin
            last_eff = AW'(MAX_KEYS - 1);
        end else begin
            last_eff = AW'(kc32 - 32'd1);
        end
    end

    always_comb begin
        o_cmd     = '0;
        o_rd_addr = r_k + AW'(1);
        unique case (r_state)
            S_IDLE: begin
                if (acc_eval) begin
                    o_cmd.start = 1'b1;
                    o_cmd.rd_en = 1'b1;
                    o_rd_addr   = '0;
                end else if (acc) begin
                    o_cmd.mem_we = 1'b1;
                end
            end
            S_SCAN: begin
                priority if (r_k != '0 && i_status.in_seg) begin
                    o_cmd.cap_seg = 1'b1;
                end else if (r_k == r_last) begin
                    o_cmd.cap_last = 1'b1;
                end else begin
                    o_cmd.adv   = 1'b1;
                    o_cmd.rd_en = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step  = 1'b1;
                o_cmd.div_first = (r_step == '0);
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
            end
            S_OUT: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_key_count <= KEY_CNT_W'(1);
            r_k         <= '0;
            r_last      <= '0;
            r_seg       <= '0;
            r_step      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_key_count <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (acc_eval) begin
                        r_k     <= '0;
                        r_last  <= last_eff;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (o_cmd.cap_seg) begin
                        r_seg   <= r_k - AW'(1);
                        r_step  <= '0;
                        r_state <= S_DIV;
                    end else if (o_cmd.cap_last) begin
                        r_seg   <= r_k;
                        r_state <= S_OUT;
                    end else begin
                        r_k <= r_k + AW'(1);
                    end
                end
                S_DIV: begin
                    if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                        r_state <= S_MUL;
                    end else begin
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                S_MUL: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_status.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_eval_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_eval |=> (r_state == S_SCAN))
        else $error("evaluate transaction did not start a scan");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_k <= r_last))
        else $error("scan index passed the last key");

    a_div_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_step < STEP_W'(DIV_STEPS)))
        else $error("divide step counter out of range");

    a_load_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (r_state == S_IDLE))
        else $error("result load did not return to idle");

endmodule
`default_nettype wire

[hw/rtl/kli_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kli_datapath
// Datapath: key memory with registered read, segment compare, restoring
// fraction divider, one signed multiply and the output register.
// ----------------------------------------------------------------------------
module kli_datapath #(
    parameter int MAX_KEYS = 64,
    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire kli_pkg::t_cmd       i_cmd,
    input  wire kli_pkg::t_in_item   i_in_data,
    input  wire logic [AW-1:0]       i_rd_addr,
    input  wire logic [AW-1:0]       i_seg,
    output kli_pkg::t_status         o_status,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output kli_pkg::t_out_item       o_out_data
);
    import kli_pkg::*;

    localparam int MEM_W = 2 * DATA_W;
    localparam int FW    = FRAC_BITS + 1;
    localparam int PW    = DATA_W + 1 + FW + 1;

    logic [MEM_W-1:0]         mem [MAX_KEYS];
    logic [MEM_W-1:0]         r_rd_data;

    logic [DATA_W-1:0]        r_pos;
    logic [DATA_W-1:0]        r_prev_t;
    logic [DATA_W-1:0]        r_prev_v;
    logic [DATA_W-1:0]        r_v0;
    logic signed [DATA_W:0]   r_diff;
    logic [DATA_W-1:0]        r_span;
    logic [DATA_W:0]          r_rem;
    logic [FW-1:0]            r_quo;
    logic signed [PW-1:0]     r_prod;
    logic                     r_lerp;
    logic                     r_noseg;
    logic                     r_out_valid;
    t_out_item                r_out;

    logic [DATA_W-1:0]        cur_t;
    logic [DATA_W-1:0]        cur_v;
    logic [AW-1:0]            wr_addr;
    logic                     idx_ok;
    logic [DATA_W:0]          trial;
    logic                     ge;
    logic [DATA_W-1:0]        result;

    assign cur_t   = r_rd_data[MEM_W-1:DATA_W];
    assign cur_v   = r_rd_data[DATA_W-1:0];
    assign wr_addr = AW'(i_in_data.key_index);
    assign idx_ok  = 32'(i_in_data.key_index) < 32'(MAX_KEYS);

    // key table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we && idx_ok) begin
            mem[wr_addr] <= {i_in_data.key_time, i_in_data.key_value};
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_status.in_seg   = (r_prev_t <= r_pos) && (r_pos <= cur_t);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    // restoring divide: first step takes the integer bit, then shift left
    assign trial = i_cmd.div_first ? r_rem : {r_rem[DATA_W-1:0], 1'b0};
    assign ge    = trial >= {1'b0, r_span};

    // v0 + floor((v1 - v0) * f / 2^16), low word only
    assign result = r_lerp ? (r_v0 + r_prod[DATA_W+FRAC_BITS-1:FRAC_BITS]) : r_v0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_pos <= i_in_data.position;
        end
        if (i_cmd.adv) begin
            r_prev_t <= cur_t;
            r_prev_v <= cur_v;
        end
        if (i_cmd.cap_seg) begin
            r_v0    <= r_prev_v;
            r_diff  <= $signed({cur_v[DATA_W-1], cur_v})
                     - $signed({r_prev_v[DATA_W-1], r_prev_v});
            r_span  <= cur_t - r_prev_t;
            r_rem   <= {1'b0, r_pos - r_prev_t};
            r_quo   <= '0;
            // zero span falls back to the lower key value
            r_lerp  <= (cur_t != r_prev_t);
            r_noseg <= 1'b0;
        end
        if (i_cmd.cap_last) begin
            r_v0    <= cur_v;
            r_lerp  <= 1'b0;
            r_noseg <= 1'b1;
        end
        if (i_cmd.div_step) begin
            r_rem <= ge ? (trial - {1'b0, r_span}) : trial;
            r_quo <= {r_quo[FW-2:0], ge};
        end
        if (i_cmd.mul) begin
            r_prod <= r_diff * $signed({1'b0, r_quo});
        end
        if (i_cmd.out_load) begin
            r_out.value      <= result;
            r_out.segment    <= KEY_IDX_W'(i_seg);
            r_out.no_segment <= r_noseg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_out_valid)
        else $error("result load did not raise output valid");

    a_rem_below_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div_step && r_lerp && !i_cmd.div_first) |-> (r_rem < {1'b0, r_span}))
        else $error("divider remainder not below span");

    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.mul && r_lerp) |-> (r_quo <= FW'(1 << FRAC_BITS)))
        else $error("fraction above one");

endmodule
`default_nettype wire

[hw/rtl/keyframe_linear_interpolator_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator_unit
// Piecewise linear interpolation over a keyframe table of Q16.16 time/value
// pairs. Key writes fill the table; evaluates return the interpolated value.
//
//   channel   direction  handshake            payload
//   cfg       in         i_cfg_we             i_cfg_data  (key count)
//   in        in         i_in_valid/o_in_ready i_in_data  (t_in_item)
//   out       out        o_out_valid/i_out_ready o_out_data (t_out_item)
//
// A key write gives no result.
// An evaluate reads key 0, then scans s keys (at most the key
// count) with one table read per cycle, then runs 17 divider steps, 1 multiply
// and 1 output load. A no-segment answer skips divide and multiply.
// The input is taken again while a result waits in the output register; a
// stalled output holds the block in its load state.
// Reset is synchronous; the key table has no reset and must be written first.
// ----------------------------------------------------------------------------
module keyframe_linear_interpolator_unit #(
    parameter int MAX_KEYS = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [kli_pkg::KEY_CNT_W-1:0] i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire kli_pkg::t_in_item             i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output kli_pkg::t_out_item                 o_out_data
);
    import kli_pkg::*;

    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

    t_cmd          cmd;
    t_status       status;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] seg;

    kli_ctrl #(
        .MAX_KEYS (MAX_KEYS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in_data.req_type),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_rd_addr  (rd_addr),
        .o_seg      (seg)
    );

    kli_datapath #(
        .MAX_KEYS (MAX_KEYS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_rd_addr   (rd_addr),
        .i_seg       (seg),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for keyframe_linear_interpolator_unit. Key writes and
// curve evaluations are queued per phase, driven over valid/ready, and every
// evaluation is predicted against a local copy of the keyframe table. Phases
// change the key count while the block is idle and vary the idle rates of
// both sides, with one long output stall to back the block up.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kli_pkg::*;

    localparam int NUM_KEYS       = 64;
    localparam int SETTLE_CYCLES  = 100;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 230;

    logic                 i_clk;
    logic                 i_rst_n  = 1'b0;
    logic                 cfg_we   = 1'b0;
    logic [KEY_CNT_W-1:0] cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    t_in_item             in_data  = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_item            out_data;

    keyframe_linear_interpolator_unit #(
        .MAX_KEYS(NUM_KEYS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    // keyframe table as the block should hold it
    logic [DATA_W-1:0]    mirror_time [NUM_KEYS];
    logic [DATA_W-1:0]    mirror_value[NUM_KEYS];
    logic [KEY_CNT_W-1:0] mirror_count = 1;

    // table contents as planned by the stimulus generator
    logic [DATA_W-1:0]    plan_time[NUM_KEYS];

    t_in_item             key_requests[$];
    t_out_item            pending_answers[$];

    int                   mismatches   = 0;
    int                   plan_items   = 0;
    int unsigned          send_idle_pct = 0;
    int unsigned          recv_idle_pct = 0;
    bit                   hold_wanted  = 1'b0;
    bit                   hold_done    = 1'b0;
    int                   hold_left    = 0;
    int                   quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned eff_keys(logic [KEY_CNT_W-1:0] cnt);
        if (cnt == 0) return 1;
        if (cnt > NUM_KEYS) return NUM_KEYS;
        return cnt;
    endfunction

    // first segment holding pos wins; otherwise answer with the last key
    function automatic t_out_item interp_curve(logic [DATA_W-1:0] pos);
        t_out_item         res;
        int unsigned       n;
        logic [DATA_W-1:0] span;
        longint unsigned   frac;
        longint            lo_v;
        longint            hi_v;
        longint            acc;
        n = eff_keys(mirror_count);
        for (int k = 0; k + 1 < n; k++) begin
            if (mirror_time[k] <= pos && pos <= mirror_time[k + 1]) begin
                span           = mirror_time[k + 1] - mirror_time[k];
                res.segment    = 6'(k);
                res.no_segment = 1'b0;
                if (span == 0) begin
                    res.value = mirror_value[k];
                end else begin
                    frac = {16'h0, pos - mirror_time[k], 16'h0} / {32'h0, span};
                    lo_v = $signed(mirror_value[k]);
                    hi_v = $signed(mirror_value[k + 1]);
                    acc  = lo_v * longint'(65536 - frac) + hi_v * longint'(frac);
                    res.value = 32'(acc >>> 16);
                end
                return res;
            end
        end
        res.value      = mirror_value[n - 1];
        res.segment    = 6'(n - 1);
        res.no_segment = 1'b1;
        return res;
    endfunction

    // driver: when the slot is free, offer the next queued transaction or, at random, stay idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                if (in_data.req_type == REQ_WRITE) begin
                    mirror_time[in_data.key_index]  = in_data.key_time;
                    mirror_value[in_data.key_index] = in_data.key_value;
                end else begin
                    pending_answers.push_back(interp_curve(in_data.position));
                end
            end
            if (!in_valid || in_ready) begin
                if (key_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_data  <= key_requests.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls, plus one long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (hold_wanted && !hold_done && out_valid) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: result with nothing expected, actual %h", $time, out_data);
                mismatches++;
            end else begin
                want = pending_answers.pop_front();
                if (want.value !== out_data.value) begin
                    $display("%0t: value expected %h actual %h",
                             $time, want.value, out_data.value);
                    mismatches++;
                end
                if (want.segment !== out_data.segment) begin
                    $display("%0t: segment expected %0d actual %0d",
                             $time, want.segment, out_data.segment);
                    mismatches++;
                end
                if (want.no_segment !== out_data.no_segment) begin
                    $display("%0t: no_segment expected %b actual %b",
                             $time, want.no_segment, out_data.no_segment);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: count cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("keyframe_linear_interpolator_unit regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(19))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_write(int unsigned slot, logic [DATA_W-1:0] t,
                               logic [DATA_W-1:0] v);
        t_in_item it;
        it.req_type  = REQ_WRITE;
        it.key_index = 6'(slot);
        it.key_time  = t;
        it.key_value = v;
        it.position  = $urandom;
        key_requests.push_back(it);
        plan_time[slot] = t;
        plan_items++;
    endtask

    task automatic queue_eval(logic [DATA_W-1:0] pos);
        t_in_item it;
        it.req_type  = REQ_EVAL;
        it.key_index = 6'($urandom);
        it.key_time  = $urandom;
        it.key_value = $urandom;
        it.position  = pos;
        key_requests.push_back(it);
        plan_items++;
    endtask

    // fill keys 0..n-1 with non-decreasing times, some spans zero
    task automatic load_sorted(int unsigned n);
        logic [DATA_W-1:0] t;
        logic [DATA_W-1:0] step;
        longint unsigned   stride;
        case ($urandom_range(3))
            0:       t = 32'h0;
            1:       t = $urandom_range(32'h0010_0000);
            2:       t = $urandom;
            default: t = 32'hFFFF_FFFF - $urandom_range(32'h0100_0000);
        endcase
        stride = (64'hFFFF_FFFF - t) / n;
        for (int i = 0; i < n; i++) begin
            queue_write(i, t, pick_value());
            step = ($urandom_range(6) == 0) ? 32'h0 : $urandom_range(32'(stride));
            t    = t + step;
        end
    endtask

    task automatic query_burst(int unsigned n, int unsigned cnt);
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        lo = plan_time[0];
        hi = plan_time[n - 1];
        if (lo > hi) begin
            lo = plan_time[n - 1];
            hi = plan_time[0];
        end
        repeat (cnt) begin
            case ($urandom_range(9))
                0:       queue_eval(plan_time[$urandom_range(n - 1)]);
                1:       queue_eval($urandom);
                default: queue_eval($urandom_range(hi, lo));
            endcase
        end
    endtask

    task automatic set_key_count(logic [KEY_CNT_W-1:0] cnt);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= cnt;
        mirror_count = cnt;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // hold until every transaction is in and every answer is out, then settle
    task automatic wait_idle();
        while (key_requests.size() != 0 || in_valid || pending_answers.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(logic [KEY_CNT_W-1:0] cnt, int unsigned send_pct,
                             int unsigned recv_pct, bit stall_out);
        int unsigned n;
        int unsigned pick;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        hold_wanted   = stall_out;
        set_key_count(cnt);
        n          = eff_keys(cnt);
        plan_items = 0;
        load_sorted(n);
        query_burst(n, 8);
        while (plan_items < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                // stray key: may break the time order
                queue_write($urandom_range(NUM_KEYS - 1), $urandom, pick_value());
            end else if (pick < 25) begin
                load_sorted(n);
                query_burst(n, $urandom_range(10, 3));
            end else begin
                query_burst(n, $urandom_range(6, 1));
            end
        end
        wait_idle();
    endtask

    initial begin
        send_idle_pct = 35;
        recv_idle_pct = 84;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single key after reset: always the last-key answer
        queue_write(0, 32'hFFFF_FFFF, 32'h8000_0000);
        queue_eval(32'h0000_0000);
        queue_eval(32'hFFFF_FFFF);
        queue_write(63, 32'h0000_0000, 32'h7FFF_FFFF);
        wait_idle();

        // zero span first, then full-scale value swings
        set_key_count(4);
        queue_write(0, 32'h0000_0100, 32'h8000_0000);
        queue_write(1, 32'h0000_0100, 32'h7FFF_FFFF);
        queue_write(2, 32'h0001_0000, 32'h8000_0000);
        queue_write(3, 32'hFFFF_FFFF, 32'hFFFF_0000);
        queue_eval(32'h0000_0000);
        queue_eval(32'h0000_0100);
        queue_eval(32'h0000_0101);
        queue_eval(32'h0000_8080);
        queue_eval(32'h0001_0000);
        queue_eval(32'h0001_0001);
        queue_eval(32'h8000_0000);
        queue_eval(32'hFFFF_FFFF);
        wait_idle();

        // past the last key
        set_key_count(3);
        queue_eval(32'hFFFF_FFFF);
        queue_eval(32'h0002_0000);
        wait_idle();

        run_phase(7'd64, 35, 84, 1'b1);
        run_phase(7'd2, 35, 84, 1'b0);
        run_phase(7'd0, 84, 35, 1'b0);
        run_phase(7'd127, 84, 35, 1'b0);
        run_phase(7'd8, 0, 0, 1'b0);
        run_phase(7'($urandom_range(NUM_KEYS, 1)), 0, 0, 1'b0);

        if (mismatches == 0) begin
            $display("keyframe_linear_interpolator_unit regression: pass");
        end else begin
            $display("keyframe_linear_interpolator_unit regression: fail");
        end
        $finish;
    end

endmodule
